// ===== rtl/core/aac_pkg.sv =====
// ----------------------------------------------------------------------------
// aac_pkg
// Shared types and constants for the annealing acceptance controller.
// ----------------------------------------------------------------------------
package aac_pkg;

    // Number of calibration items before annealing starts
    localparam int CALIB_SAMPLES = 100;
    // Width of the saturating step counter
    localparam int STEP_WIDTH    = 24;
    localparam int CAL_W         = $clog2(CALIB_SAMPLES + 1);

    // ln(2) in Q0.32 and ln(100) in Q16.16
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [31:0] LN100_Q16 = 32'd301804;
    // exp(-x) is taken as zero from x = 23.0 (Q16.16) upward
    localparam logic [63:0] EXP_LIMIT = 64'd23 << 16;
    // Last series term index
    localparam logic [3:0]  SER_LAST  = 4'd12;

    // Register indexes
    localparam logic [1:0] REG_DECAY_RATE = 2'd0;
    localparam logic [1:0] REG_STALL_LIM  = 2'd1;
    localparam logic [1:0] REG_STOP_TEMP  = 2'd2;

    // Register reset values
    localparam logic [15:0] DECAY_RESET = 16'd66;
    localparam logic [15:0] STALL_RESET = 16'd1000;
    localparam logic [30:0] STOP_RESET  = 31'd655;

    // Decision codes
    localparam logic [1:0] DEC_CAL = 2'd0;
    localparam logic [1:0] DEC_ACC = 2'd1;
    localparam logic [1:0] DEC_REJ = 2'd2;
    localparam logic [1:0] DEC_FIN = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_CAL,
        S_XSET,
        S_NSET,
        S_DIV,
        S_DIV_END,
        S_SER_M1,
        S_SER_M2,
        S_SER_M3,
        S_SER_FIX,
        S_EXP_SHIFT,
        S_EXP_END,
        S_AMUL,
        S_ACHK,
        S_TMUL,
        S_TEND,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        DIV_INIT,
        DIV_X,
        DIV_N
    } t_div_op;

    // floor(2^32 / k) for the series divisions, k = 2..12
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd2:    v = 32'd2147483648;
            4'd3:    v = 32'd1431655765;
            4'd4:    v = 32'd1073741824;
            4'd5:    v = 32'd858993459;
            4'd6:    v = 32'd715827882;
            4'd7:    v = 32'd613566756;
            4'd8:    v = 32'd536870912;
            4'd9:    v = 32'd477218588;
            4'd10:   v = 32'd429496729;
            4'd11:   v = 32'd390451572;
            4'd12:   v = 32'd357913941;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/annealing_acceptance_controller_unit.sv =====
// ----------------------------------------------------------------------------
// annealing_acceptance_controller_unit
// Metropolis acceptance controller with calibrated start temperature and
// exponential cooling, built around one shared multiplier and one serial
// restoring divider under a sequencer.
// ----------------------------------------------------------------------------
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | i_in_valid / o_in_stall, cost and fraction  | item in
//  out     | o_out_valid / i_out_stall, decision, temp   | item out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data           | write only
//
//  Calibration and finished items go straight to output; the last calibration
//  item first divides the cost sum by ln(100). A worse candidate takes a 21-step
//  divide by the temperature, two exponentials (6-step divide, 11 series terms)
//  and two products; a better or equal one skips the first divide and exponential.
//  Synchronous active-low reset clears all annealing state and loads the registers with their reset values.
//  Input stalls while an item is in work; a result waits in the output register.
// ----------------------------------------------------------------------------
module annealing_acceptance_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_current_cost,
    input  logic [31:0] i_candidate_cost,
    input  logic [15:0] i_random_fraction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_decision,
    output logic [31:0] o_temperature_out,
    output logic        o_finished,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    aac_pkg::t_state r_state, n_state;

    // Configuration
    logic [15:0] r_decay;
    logic [15:0] r_stall_lim;
    logic [30:0] r_stop;

    // Captured item
    logic signed [31:0] r_cur;
    logic signed [31:0] r_cand;
    logic [15:0]        r_rnd;

    // Annealing state
    logic signed [31:0]             r_temp;
    logic signed [31:0]             r_init;
    logic signed [39:0]             r_dsum;
    logic [aac_pkg::CAL_W-1:0]      r_cal_cnt;
    logic [15:0]                    r_stall;
    logic [aac_pkg::STEP_WIDTH-1:0] r_step;
    logic                           r_done;

    // Working registers
    logic [1:0]  r_dec;
    logic        r_reject;
    logic        r_temp_phase;
    logic [31:0] r_diff;
    logic [20:0] r_xval;
    logic [63:0] r_prod;
    logic [31:0] r_p;
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_term;
    logic [32:0] r_sum;
    logic [3:0]  r_k;
    logic [5:0]  r_n;
    logic [32:0] r_exp;

    // Divider
    aac_pkg::t_div_op r_div_op;
    logic [31:0] r_div_rem;
    logic [31:0] r_div_feed;
    logic [31:0] r_div_den;
    logic [31:0] r_div_quo;
    logic [5:0]  r_div_cnt;
    logic        r_div_ovf;

    // Output register
    logic        r_out_valid;
    logic [1:0]  r_out_dec;
    logic [31:0] r_out_temp;
    logic        r_out_fin;

    // Combinational helpers
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [32:0] div_shift, div_sub;
    logic        div_ge;
    logic        in_acc, out_free;
    logic        calib_item, cal_last, stop_now;
    logic signed [39:0] dsum_new;
    logic [39:0] mag;
    logic        quo_big;
    logic signed [31:0] init_v;
    logic        x_sat, a_sat;
    logic [31:0] fix_rem;
    logic [31:0] term_new;
    logic signed [31:0] t_new;
    logic [15:0] stall_new;

    function automatic logic f_stop(input logic signed [31:0] t, input logic [15:0] st,
                                    input logic [30:0] stop, input logic [15:0] lim);
        return (t <= $signed({1'b0, stop})) || (st >= lim);
    endfunction

    // Shared datapath terms
    always_comb begin
        in_acc     = i_in_valid && (r_state == aac_pkg::S_IDLE);
        out_free   = !r_out_valid || !i_out_stall;
        calib_item = (r_cal_cnt < aac_pkg::CAL_W'(aac_pkg::CALIB_SAMPLES)) && !r_done;
        cal_last   = (r_cal_cnt + 1'b1) == aac_pkg::CAL_W'(aac_pkg::CALIB_SAMPLES);
        stop_now   = f_stop(r_temp, r_stall, r_stop, r_stall_lim);
        dsum_new   = r_dsum + (40'(r_cur) - 40'(r_cand));
        mag        = r_dsum[39] ? 40'(-r_dsum) : 40'(r_dsum);

        div_shift  = {r_div_rem, r_div_feed[31]};
        div_ge     = div_shift >= {1'b0, r_div_den};
        div_sub    = div_shift - {1'b0, r_div_den};

        quo_big    = r_div_ovf || r_div_quo[31];
        if (r_dsum[39]) begin
            init_v = quo_big ? 32'sh8000_0000 : $signed(-r_div_quo);
        end else begin
            init_v = quo_big ? 32'sh7FFF_FFFF : $signed(r_div_quo);
        end
        // only the 21 fresh quotient bits belong to x
        x_sat      = r_div_ovf || ({43'd0, r_div_quo[20:0]} >= aac_pkg::EXP_LIMIT);
        a_sat      = r_prod >= aac_pkg::EXP_LIMIT;

        fix_rem    = r_p - r_prod[31:0];
        term_new   = (fix_rem >= {28'd0, r_k}) ? r_q + 32'd1 : r_q;

        t_new      = r_exp[32] ? r_init : $signed(r_prod[63:32]);
        if (r_reject) begin
            stall_new = (r_stall != 16'hFFFF) ? r_stall + 16'd1 : r_stall;
        end else begin
            stall_new = 16'd0;
        end
    end

    // Select multiplier operands
    always_comb begin
        case (r_state)
            aac_pkg::S_SER_M1: begin
                mul_a = r_term;
                mul_b = r_r;
            end
            aac_pkg::S_SER_M2: begin
                mul_a = r_prod[63:32];
                mul_b = aac_pkg::recip_k(r_k);
            end
            aac_pkg::S_SER_M3: begin
                mul_a = r_prod[63:32];
                mul_b = {28'd0, r_k};
            end
            aac_pkg::S_AMUL: begin
                mul_a = {16'd0, r_decay};
                mul_b = 32'(r_step);
            end
            aac_pkg::S_TMUL: begin
                mul_a = r_init;
                mul_b = r_exp[31:0];
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aac_pkg::S_IDLE:      if (in_acc) n_state = aac_pkg::S_DISP;
            aac_pkg::S_DISP: begin
                if (calib_item) begin
                    n_state = cal_last ? aac_pkg::S_CAL : aac_pkg::S_FIN;
                end else if (r_done || stop_now) begin
                    n_state = aac_pkg::S_FIN;
                end else if (r_cur < r_cand) begin
                    n_state = aac_pkg::S_XSET;
                end else begin
                    n_state = aac_pkg::S_AMUL;
                end
            end
            aac_pkg::S_CAL, aac_pkg::S_XSET, aac_pkg::S_NSET: n_state = aac_pkg::S_DIV;
            aac_pkg::S_DIV: begin
                if (r_div_ovf || r_div_cnt == 6'd1) n_state = aac_pkg::S_DIV_END;
            end
            aac_pkg::S_DIV_END: begin
                unique case (r_div_op)
                    aac_pkg::DIV_INIT: n_state = aac_pkg::S_FIN;
                    aac_pkg::DIV_X:    n_state = x_sat ? aac_pkg::S_EXP_END : aac_pkg::S_NSET;
                    default:           n_state = aac_pkg::S_SER_M1;
                endcase
            end
            aac_pkg::S_SER_M1:    n_state = aac_pkg::S_SER_M2;
            aac_pkg::S_SER_M2:    n_state = aac_pkg::S_SER_M3;
            aac_pkg::S_SER_M3:    n_state = aac_pkg::S_SER_FIX;
            aac_pkg::S_SER_FIX: begin
                n_state = (r_k == aac_pkg::SER_LAST) ? aac_pkg::S_EXP_SHIFT
                                                     : aac_pkg::S_SER_M1;
            end
            aac_pkg::S_EXP_SHIFT: n_state = aac_pkg::S_EXP_END;
            aac_pkg::S_EXP_END:   n_state = r_temp_phase ? aac_pkg::S_TMUL : aac_pkg::S_AMUL;
            aac_pkg::S_AMUL:      n_state = aac_pkg::S_ACHK;
            aac_pkg::S_ACHK:      n_state = a_sat ? aac_pkg::S_EXP_END : aac_pkg::S_NSET;
            aac_pkg::S_TMUL:      n_state = aac_pkg::S_TEND;
            aac_pkg::S_TEND:      n_state = aac_pkg::S_FIN;
            aac_pkg::S_FIN:       if (out_free) n_state = aac_pkg::S_IDLE;
            default:              n_state = aac_pkg::S_IDLE;
        endcase
    end

    // Port outputs
    always_comb begin
        o_in_stall        = (r_state != aac_pkg::S_IDLE);
        o_out_valid       = r_out_valid;
        o_decision        = r_out_dec;
        o_temperature_out = r_out_temp;
        o_finished        = r_out_fin;
    end

    // Sequencer state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aac_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_decay     <= aac_pkg::DECAY_RESET;
            r_stall_lim <= aac_pkg::STALL_RESET;
            r_stop      <= aac_pkg::STOP_RESET;
        end else begin
            r_state <= n_state;
            // hold result until taken, load a new one when the slot frees
            if (r_state == aac_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aac_pkg::REG_DECAY_RATE: r_decay     <= i_cfg_data[15:0];
                    aac_pkg::REG_STALL_LIM:  r_stall_lim <= i_cfg_data[15:0];
                    aac_pkg::REG_STOP_TEMP:  r_stop      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Annealing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp    <= '0;
            r_init    <= '0;
            r_dsum    <= '0;
            r_cal_cnt <= '0;
            r_stall   <= '0;
            r_step    <= '0;
            r_done    <= 1'b0;
        end else begin
            case (r_state)
                aac_pkg::S_DISP: begin
                    if (calib_item) begin
                        r_dsum    <= dsum_new;
                        r_cal_cnt <= r_cal_cnt + 1'b1;
                    end else if (r_done || stop_now) begin
                        r_done <= 1'b1;
                    end
                end
                aac_pkg::S_DIV_END: begin
                    if (r_div_op == aac_pkg::DIV_INIT) begin
                        r_init <= init_v;
                        r_temp <= init_v;
                        if (f_stop(init_v, r_stall, r_stop, r_stall_lim)) r_done <= 1'b1;
                    end
                end
                aac_pkg::S_TEND: begin
                    r_temp  <= t_new;
                    r_stall <= stall_new;
                    if (r_step != '1) r_step <= r_step + 1'b1;
                    if (f_stop(t_new, stall_new, r_stop, r_stall_lim)) r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath: capture, divider, series and product steps
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_acc) begin
            r_cur  <= $signed(i_current_cost);
            r_cand <= $signed(i_candidate_cost);
            r_rnd  <= i_random_fraction;
        end
        case (r_state)
            aac_pkg::S_DISP: begin
                r_reject     <= 1'b0;
                r_temp_phase <= 1'b0;
                r_diff       <= 32'(r_cand - r_cur);
                if (calib_item) begin
                    r_dec <= aac_pkg::DEC_CAL;
                end else if (r_done || stop_now) begin
                    r_dec <= aac_pkg::DEC_FIN;
                end
            end
            aac_pkg::S_CAL: begin
                r_div_op   <= aac_pkg::DIV_INIT;
                r_div_rem  <= {8'd0, mag[39:16]};
                r_div_feed <= {mag[15:0], 16'd0};
                r_div_den  <= aac_pkg::LN100_Q16;
                r_div_cnt  <= 6'd32;
                r_div_ovf  <= {8'd0, mag[39:16]} >= aac_pkg::LN100_Q16;
            end
            aac_pkg::S_XSET: begin
                r_div_op   <= aac_pkg::DIV_X;
                r_div_rem  <= {5'd0, r_diff[31:5]};
                r_div_feed <= {r_diff[4:0], 27'd0};
                r_div_den  <= r_temp;
                r_div_cnt  <= 6'd21;
                r_div_ovf  <= {5'd0, r_diff[31:5]} >= r_temp;
            end
            aac_pkg::S_NSET: begin
                r_div_op   <= aac_pkg::DIV_N;
                r_div_rem  <= {1'b0, r_xval, 10'd0};
                r_div_feed <= 32'd0;
                r_div_den  <= aac_pkg::LN2_Q32;
                r_div_cnt  <= 6'd6;
                r_div_ovf  <= 1'b0;
            end
            aac_pkg::S_DIV: begin
                // one quotient bit per cycle
                r_div_rem  <= div_ge ? div_sub[31:0] : div_shift[31:0];
                r_div_feed <= {r_div_feed[30:0], 1'b0};
                r_div_quo  <= {r_div_quo[30:0], div_ge};
                r_div_cnt  <= r_div_cnt - 6'd1;
            end
            aac_pkg::S_DIV_END: begin
                r_dec <= aac_pkg::DEC_CAL;
                if (r_div_op == aac_pkg::DIV_X) begin
                    if (x_sat) r_exp <= 33'd0;
                    r_xval <= r_div_quo[20:0];
                end else if (r_div_op == aac_pkg::DIV_N) begin
                    r_n    <= r_div_quo[5:0];
                    r_r    <= r_div_rem;
                    r_term <= r_div_rem;
                    r_sum  <= 33'h1_0000_0000 - {1'b0, r_div_rem};
                    r_k    <= 4'd2;
                end
            end
            aac_pkg::S_SER_M2: r_p <= r_prod[63:32];
            aac_pkg::S_SER_M3: r_q <= r_prod[63:32];
            aac_pkg::S_SER_FIX: begin
                // add even terms, subtract odd ones
                r_term <= term_new;
                r_sum  <= r_k[0] ? r_sum - {1'b0, term_new} : r_sum + {1'b0, term_new};
                r_k    <= r_k + 4'd1;
            end
            aac_pkg::S_EXP_SHIFT: r_exp <= r_sum >> r_n;
            aac_pkg::S_EXP_END: begin
                if (!r_temp_phase) r_reject <= {1'b0, r_rnd} > r_exp[32:16];
            end
            aac_pkg::S_AMUL: r_temp_phase <= 1'b1;
            aac_pkg::S_ACHK: begin
                if (a_sat) r_exp <= 33'd0;
                r_xval <= r_prod[20:0];
            end
            aac_pkg::S_TEND: r_dec <= r_reject ? aac_pkg::DEC_REJ : aac_pkg::DEC_ACC;
            default: ;
        endcase
        // advance result into the output register
        if (r_state == aac_pkg::S_FIN && out_free) begin
            r_out_dec  <= r_dec;
            r_out_temp <= r_temp;
            r_out_fin  <= r_done;
        end
    end

    // Finished flag never drops
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("done flag dropped");

    // Divider never runs with an empty count
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aac_pkg::S_DIV) |-> (r_div_cnt != 6'd0))
        else $error("divider count empty");

    // Series index stays within the term range
    a_ser_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aac_pkg::S_SER_FIX) |-> (r_k >= 4'd2 && r_k <= aac_pkg::SER_LAST))
        else $error("series index out of range");

    // Division by temperature only with a positive temperature
    a_temp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aac_pkg::S_XSET) |-> (r_temp > 0))
        else $error("divide by non-positive temperature");

    // A finished decision always carries the finished flag
    a_fin_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dec == aac_pkg::DEC_FIN) |-> r_out_fin)
        else $error("finished decision without flag");

endmodule
